[rtl/core/ipv4rx_pkg.sv]
// ---------------------------------------------------------------------------
// ipv4rx_pkg: shared types and constants of the IPv4 receive header filter
// Verdict codes, header field bundle, protocol numbers and register indexes.
// ---------------------------------------------------------------------------
package ipv4rx_pkg;

  localparam int CNT_W = 12;  // frame byte counter width

  localparam logic [4:0]  IPV4_HDR_BYTES = 5'd20;
  localparam logic [15:0] IPV4_HDR_LEN16 = 16'd20;
  localparam logic [15:0] MF_BIT         = 16'h2000;
  localparam logic [15:0] OFFSET_MASK    = 16'h1fff;
  localparam logic [3:0]  NIBBLE_MASK    = 4'h0f;
  localparam logic [15:0] SUM_GOOD       = 16'hffff;
  localparam logic [3:0]  IP_VERSION     = 4'd4;
  localparam logic [3:0]  IHL_NO_OPTIONS = 4'd5;
  localparam logic [7:0]  LOOPBACK_NET   = 8'd127;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] PROTO_TCP  = 8'd6;

  // configuration register indexes
  localparam logic CFG_OWN_ADDRESS = 1'b0;
  localparam logic CFG_SUBNET_MASK = 1'b1;

  typedef enum logic [3:0] {
    VERDICT_ICMP     = 4'd0,
    VERDICT_UDP      = 4'd1,
    VERDICT_TCP      = 4'd2,
    VERDICT_SHORT    = 4'd3,
    VERDICT_VERSION  = 4'd4,
    VERDICT_OPTIONS  = 4'd5,
    VERDICT_LENGTH   = 4'd6,
    VERDICT_CHECKSUM = 4'd7,
    VERDICT_FRAGMENT = 4'd8,
    VERDICT_NOT_OURS = 4'd9,
    VERDICT_PROTOCOL = 4'd10
  } verdict_t;

  // captured header fields handed to the verdict logic
  typedef struct packed {
    logic [7:0]  ver_len;
    logic [15:0] total_len;
    logic [15:0] frag;
    logic [7:0]  proto;
    logic [15:0] hdr_sum;
    logic [31:0] dst_addr;
  } hdr_fields_t;

endpackage

[rtl/core/ipv4rx_judge.sv]
// ---------------------------------------------------------------------------
// ipv4rx_judge: frame verdict
// Ordered drop checks over the captured header, protocol classification, plus payload length.
// ---------------------------------------------------------------------------
module ipv4rx_judge #(
  parameter int LINK_HEADER_BYTES = 14
) (
  input  ipv4rx_pkg::hdr_fields_t         fields,
  input  logic [ipv4rx_pkg::CNT_W-1:0]    frame_len,
  input  logic [31:0]                     own_address,
  input  logic [31:0]                     subnet_mask,
  output ipv4rx_pkg::verdict_t            verdict,
  output logic [15:0]                     payload_length
);
  import ipv4rx_pkg::*;

  localparam logic [CNT_W-1:0] MIN_FRAME = CNT_W'(LINK_HEADER_BYTES + 20);
  localparam logic [15:0]      LINK_LEN16 = 16'(LINK_HEADER_BYTES);

  logic [15:0] avail;
  logic        dst_ours;

  assign avail = 16'(frame_len) - LINK_LEN16;

  assign dst_ours = (fields.dst_addr == own_address) ||
                    (fields.dst_addr[31:24] == LOOPBACK_NET) ||
                    (fields.dst_addr == 32'hffff_ffff) ||
                    ((subnet_mask != 32'd0) &&
                     (fields.dst_addr == (own_address | ~subnet_mask)));

  always_comb begin
    priority if (frame_len < MIN_FRAME) begin
      verdict = VERDICT_SHORT;
    end else if (fields.ver_len[7:4] != IP_VERSION) begin
      verdict = VERDICT_VERSION;
    end else if ((fields.ver_len[3:0] & NIBBLE_MASK) != IHL_NO_OPTIONS) begin
      verdict = VERDICT_OPTIONS;
    end else if (fields.total_len < IPV4_HDR_LEN16 || fields.total_len > avail) begin
      verdict = VERDICT_LENGTH;
    end else if (fields.hdr_sum != SUM_GOOD) begin
      verdict = VERDICT_CHECKSUM;
    end else if ((fields.frag & (MF_BIT | OFFSET_MASK)) != 16'd0) begin
      verdict = VERDICT_FRAGMENT;
    end else if (!dst_ours) begin
      verdict = VERDICT_NOT_OURS;
    end else if (fields.proto == PROTO_ICMP) begin
      verdict = VERDICT_ICMP;
    end else if (fields.proto == PROTO_UDP) begin
      verdict = VERDICT_UDP;
    end else if (fields.proto == PROTO_TCP) begin
      verdict = VERDICT_TCP;
    end else begin
      verdict = VERDICT_PROTOCOL;
    end
  end

  assign payload_length = (verdict == VERDICT_ICMP || verdict == VERDICT_UDP ||
                           verdict == VERDICT_TCP) ?
                          (fields.total_len - IPV4_HDR_LEN16) : 16'd0;

endmodule

[rtl/core/ipv4_receive_header_filter.sv]
// ---------------------------------------------------------------------------
// ipv4_receive_header_filter: IPv4 receive header filter
// Byte stream in, one verdict per frame out with addresses and payload length.
// ---------------------------------------------------------------------------
// Path: the last byte passes the input register, then the result register,
//   which raises out_tvalid with the verdict.
// Throughput: one byte per cycle unless a last byte waits on a pending verdict;
//   the byte counter and header sum keep pace, so frames may follow with no gap.
// Reset: synchronous, active low; clears frame state, config and valids.
module ipv4_receive_header_filter #(
  parameter int MAX_FRAME_LEN     = 2048,  // byte count saturates here
  parameter int LINK_HEADER_BYTES = 14     // bytes skipped before the IP header
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  // byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  // verdicts
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata   // [3:0] verdict, [35:4] source_address,
                                  // [67:36] dest_address, [83:68] payload_length,
                                  // [87:84] zero
);
  import ipv4rx_pkg::*;

  localparam logic [CNT_W-1:0] LINK_CNT = CNT_W'(LINK_HEADER_BYTES);
  localparam logic [CNT_W-1:0] HDR_END  = CNT_W'(LINK_HEADER_BYTES + 20);
  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_FRAME_LEN);

  // config registers
  logic [31:0] own_addr_r, subnet_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r    <= 32'd0;
      subnet_mask_r <= 32'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_OWN_ADDRESS: own_addr_r    <= cfg_wdata;
        CFG_SUBNET_MASK: subnet_mask_r <= cfg_wdata;
        default:         own_addr_r    <= own_addr_r;
      endcase
    end
  end

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       advance;
  logic       in_req;

  // a non-last byte never produces a verdict, so it moves on even while
  // the result register is stalled
  assign advance   = s1_valid_r && (!s1_last_r || !out_tvalid || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_req    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // per-frame state
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]      sum_r, sum_nxt;
  logic [7:0]       hold_r, hold_nxt;
  logic [7:0]       vl_r, vl_nxt;
  logic [15:0]      tlen_r, tlen_nxt;
  logic [15:0]      frag_r, frag_nxt;
  logic [7:0]       proto_r, proto_nxt;
  logic [31:0]      src_r, src_nxt;
  logic [31:0]      dst_r, dst_nxt;

  logic       in_hdr;
  logic [4:0] hdr_pos;
  logic [16:0] sum_ext;

  assign in_hdr  = (cnt_r >= LINK_CNT) && (cnt_r < HDR_END);
  assign hdr_pos = 5'(cnt_r - LINK_CNT);
  // one's-complement add of the completed 16-bit header word
  assign sum_ext = {1'b0, sum_r} + {1'b0, hold_r, s1_byte_r};

  always_comb begin
    cnt_nxt   = (cnt_r < MAX_CNT) ? cnt_r + CNT_W'(1) : cnt_r;
    sum_nxt   = sum_r;
    hold_nxt  = hold_r;
    vl_nxt    = vl_r;
    tlen_nxt  = tlen_r;
    frag_nxt  = frag_r;
    proto_nxt = proto_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    if (in_hdr) begin
      if (!hdr_pos[0]) begin
        hold_nxt = s1_byte_r;
      end else begin
        sum_nxt = sum_ext[15:0] + {15'd0, sum_ext[16]};  // end-around carry
      end
      unique case (hdr_pos)
        5'd0:                      vl_nxt    = s1_byte_r;
        5'd2, 5'd3:                tlen_nxt  = {tlen_r[7:0], s1_byte_r};
        5'd6, 5'd7:                frag_nxt  = {frag_r[7:0], s1_byte_r};
        5'd9:                      proto_nxt = s1_byte_r;
        5'd12, 5'd13, 5'd14, 5'd15: src_nxt  = {src_r[23:0], s1_byte_r};
        5'd16, 5'd17, 5'd18, 5'd19: dst_nxt  = {dst_r[23:0], s1_byte_r};
        default:                   hold_nxt  = hold_nxt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (advance && s1_last_r)) begin
      // frame done: back to the reset state
      cnt_r   <= '0;
      sum_r   <= 16'd0;
      hold_r  <= 8'd0;
      vl_r    <= 8'd0;
      tlen_r  <= 16'd0;
      frag_r  <= 16'd0;
      proto_r <= 8'd0;
      src_r   <= 32'd0;
      dst_r   <= 32'd0;
    end else if (advance) begin
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      hold_r  <= hold_nxt;
      vl_r    <= vl_nxt;
      tlen_r  <= tlen_nxt;
      frag_r  <= frag_nxt;
      proto_r <= proto_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
    end
  end

  // verdict on the state as it stands after the last byte
  hdr_fields_t fields;
  verdict_t    verdict;
  logic [15:0] payload_len;

  assign fields = '{ver_len: vl_nxt, total_len: tlen_nxt, frag: frag_nxt,
                    proto: proto_nxt, hdr_sum: sum_nxt, dst_addr: dst_nxt};

  ipv4rx_judge #(
    .LINK_HEADER_BYTES(LINK_HEADER_BYTES)
  ) u_judge (
    .fields         (fields),
    .frame_len      (cnt_nxt),
    .own_address    (own_addr_r),
    .subnet_mask    (subnet_mask_r),
    .verdict        (verdict),
    .payload_length (payload_len)
  );

  // result register
  logic        out_valid_r;
  logic [87:0] out_data_r;
  logic        load;

  assign load = advance && s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= {4'd0, payload_len, dst_nxt, src_nxt, verdict};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_cnt_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_CNT)
    else $error("byte count above saturation limit");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (cnt_r == '0 && sum_r == 16'd0 && dst_r == 32'd0))
    else $error("frame state not cleared after verdict");

  a_drop_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[3:0] > 4'(VERDICT_TCP)) |-> (out_tdata[83:68] == 16'd0))
    else $error("dropped frame carries a payload length");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !load)
    else $error("pending verdict overwritten");

endmodule
